### src/ebga_pkg.sv
// shared types, widths and constants for the gated echo burst averager
package ebga_pkg;

    // payload widths
    localparam int TICKS_W = 16;
    localparam int DIST_W  = 21;

    // configuration port
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W     = 6;
    localparam int DIVR_W    = 10;
    localparam int TOL_W     = 10;
    localparam int MINV_W    = 6;

    // default burst capacity
    localparam int DEF_MAX_BURST = 32;

    // ticks to distance factor
    localparam logic [4:0] TICK_FACTOR = 5'd18;

    // register reset values
    localparam logic [LEN_W-1:0]  RST_BURST_LENGTH  = 6'd10;
    localparam logic [DIVR_W-1:0] RST_SCALE_DIVISOR = 10'd100;
    localparam logic [TOL_W-1:0]  RST_TOLERANCE     = 10'd50;
    localparam logic [MINV_W-1:0] RST_MIN_VALID     = 6'd4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BURST_LENGTH  = 2'd0,
        REG_SCALE_DIVISOR = 2'd1,
        REG_TOLERANCE     = 2'd2,
        REG_MIN_VALID     = 2'd3
    } ebga_reg_e;

    // input transaction
    typedef struct packed {
        logic               timed_out;
        logic [TICKS_W-1:0] echo_ticks;
    } ebga_in_t;

    // result transaction
    typedef struct packed {
        logic [DIST_W-1:0] distance_scaled;
        logic              result_valid;
    } ebga_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic accum;
        logic div_mean;
        logic div_scale;
        logic emit_ok;
        logic emit_zero;
    } ebga_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic burst_end;
        logic enough_valid;
        logic div_done;
    } ebga_status_t;

endpackage

### src/ebga_div.sv
// iterative restoring divider, one quotient bit per cycle
module ebga_div #(
    parameter int W = 27
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    logic             running_reg, running_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     q_reg, q_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W:0]       rem_shift;
    logic [W:0]       diff;

    // one shift and trial subtract per cycle
    always_comb
    begin
        rem_shift    = {rem_reg, q_reg[W-1]};
        diff         = rem_shift - {1'b0, den_reg};
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        den_next     = den_reg;
        if (load)
        begin
            running_next = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            q_next       = dividend;
            den_next     = divisor;
        end
        else if (running_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            if (cnt_reg == LAST_STEP)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### src/ebga_dp.sv
// datapath: config registers, gating, burst accumulation and result register
module ebga_dp #(
    parameter int MAX_BURST = ebga_pkg::DEF_MAX_BURST
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  ebga_pkg::ebga_reg_e            cfg_index,
    input  logic [ebga_pkg::CFG_W-1:0]     cfg_data,
    input  ebga_pkg::ebga_in_t             sample,
    input  ebga_pkg::ebga_cmd_t            cmd,
    output ebga_pkg::ebga_status_t         status,
    output ebga_pkg::ebga_out_t            result,
    output logic                           done
);
    import ebga_pkg::*;

    localparam int CNT_W = $clog2(MAX_BURST + 1);
    localparam int SUM_W = DIST_W + CNT_W;
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int CMP_V = (CMP_W > MINV_W) ? CMP_W : MINV_W;

    logic [LEN_W-1:0]  burst_length_reg;
    logic [DIVR_W-1:0] scale_divisor_reg;
    logic [TOL_W-1:0]  tolerance_reg;
    logic [MINV_W-1:0] min_valid_reg;

    ebga_in_t          item_reg;
    logic [CNT_W-1:0]  sample_index_reg, sample_index_next;
    logic [CNT_W-1:0]  accepted_count_reg, accepted_count_next;
    logic [DIST_W-1:0] last_accepted_reg, last_accepted_next;
    logic [SUM_W-1:0]  distance_sum_reg, distance_sum_next;
    ebga_out_t         result_reg, result_next;
    logic              done_reg, done_next;

    logic [DIST_W-1:0] echo_dist;
    logic [DIST_W-1:0] win_lo;
    logic [DIST_W:0]   win_hi;
    logic              take;
    logic [CMP_W-1:0]  eff_len;
    logic [DIVR_W-1:0] scale_eff;
    logic              div_load;
    logic [SUM_W-1:0]  div_dividend;
    logic [SUM_W-1:0]  div_divisor;
    logic              div_done;
    logic [SUM_W-1:0]  div_quotient;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_length_reg  <= RST_BURST_LENGTH;
            scale_divisor_reg <= RST_SCALE_DIVISOR;
            tolerance_reg     <= RST_TOLERANCE;
            min_valid_reg     <= RST_MIN_VALID;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BURST_LENGTH:  burst_length_reg  <= cfg_data[LEN_W-1:0];
                REG_SCALE_DIVISOR: scale_divisor_reg <= cfg_data[DIVR_W-1:0];
                REG_TOLERANCE:     tolerance_reg     <= cfg_data[TOL_W-1:0];
                REG_MIN_VALID:     min_valid_reg     <= cfg_data[MINV_W-1:0];
                default:           ;
            endcase
        end
    end

    // distance and acceptance window around the last accepted distance
    always_comb
    begin
        echo_dist = DIST_W'(item_reg.echo_ticks) * DIST_W'(TICK_FACTOR);
        win_lo    = (last_accepted_reg > DIST_W'(tolerance_reg))
                    ? last_accepted_reg - DIST_W'(tolerance_reg) : '0;
        win_hi    = {1'b0, last_accepted_reg} + (DIST_W+1)'(tolerance_reg);
        take      = (accepted_count_reg == '0)
                    || ((echo_dist >= win_lo) && ({1'b0, echo_dist} <= win_hi));
    end

    // effective burst length and divisor
    always_comb
    begin
        if (burst_length_reg == '0)
            eff_len = CMP_W'(1);
        else if (CMP_W'(burst_length_reg) > CMP_W'(MAX_BURST))
            eff_len = CMP_W'(MAX_BURST);
        else
            eff_len = CMP_W'(burst_length_reg);
        scale_eff = (scale_divisor_reg == '0) ? DIVR_W'(1) : scale_divisor_reg;
    end

    // status back to the controller
    always_comb
    begin
        status.burst_end    = CMP_W'(sample_index_reg) >= eff_len;
        status.enough_valid = (accepted_count_reg != '0)
                              && (CMP_V'(accepted_count_reg) > CMP_V'(min_valid_reg));
        status.div_done     = div_done;
    end

    // shared divider: mean first, then scaling
    always_comb
    begin
        div_load     = cmd.div_mean | cmd.div_scale;
        div_dividend = cmd.div_mean ? distance_sum_reg : div_quotient;
        div_divisor  = cmd.div_mean ? SUM_W'(accepted_count_reg) : SUM_W'(scale_eff);
    end

    ebga_div #(
        .W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // burst state update and result load
    always_comb
    begin
        sample_index_next   = sample_index_reg;
        accepted_count_next = accepted_count_reg;
        last_accepted_next  = last_accepted_reg;
        distance_sum_next   = distance_sum_reg;
        result_next         = result_reg;
        done_next           = 1'b0;
        if (cmd.accum)
        begin
            sample_index_next = sample_index_reg + 1'b1;
            if (!item_reg.timed_out && take)
            begin
                accepted_count_next = accepted_count_reg + 1'b1;
                last_accepted_next  = echo_dist;
                distance_sum_next   = distance_sum_reg + SUM_W'(echo_dist);
            end
        end
        if (cmd.emit_ok || cmd.emit_zero)
        begin
            sample_index_next   = '0;
            accepted_count_next = '0;
            last_accepted_next  = '0;
            distance_sum_next   = '0;
            done_next           = 1'b1;
            result_next.distance_scaled = cmd.emit_ok ? div_quotient[DIST_W-1:0] : '0;
            result_next.result_valid    = cmd.emit_ok;
        end
    end

    // burst state and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg   <= '0;
            accepted_count_reg <= '0;
            last_accepted_reg  <= '0;
            distance_sum_reg   <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            sample_index_reg   <= sample_index_next;
            accepted_count_reg <= accepted_count_next;
            last_accepted_reg  <= last_accepted_next;
            distance_sum_reg   <= distance_sum_next;
            done_reg           <= done_next;
        end
    end

    // input capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= sample;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

### src/ebga_ctrl.sv
// controller: sequences capture, accumulation, the two divisions and the result
module ebga_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  ebga_pkg::ebga_status_t status,
    output ebga_pkg::ebga_cmd_t    cmd,
    output logic                   busy
);
    import ebga_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_ACCUM     = 7'b0000010,
        ST_CHECK     = 7'b0000100,
        ST_DIV_MEAN  = 7'b0001000,
        ST_DIV_SCALE = 7'b0010000,
        ST_EMIT      = 7'b0100000,
        ST_EMIT_ZERO = 7'b1000000
    } ebga_state_t;

    ebga_state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!status.burst_end)
                    state_next = ST_IDLE;
                else if (status.enough_valid)
                begin
                    cmd.div_mean = 1'b1;
                    state_next   = ST_DIV_MEAN;
                end
                else
                    state_next = ST_EMIT_ZERO;
            end
            ST_DIV_MEAN:
            begin
                if (status.div_done)
                begin
                    cmd.div_scale = 1'b1;
                    state_next    = ST_DIV_SCALE;
                end
            end
            ST_DIV_SCALE:
            begin
                if (status.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_ok = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_EMIT_ZERO:
            begin
                cmd.emit_zero = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### src/echo_burst_gated_average.sv
// top level: gated burst averager for echo time measurements
// an echo is taken when start is high and busy is low; busy then stays high through the accumulate and check states
// a burst end with too few accepted echoes raises the done strobe after the accumulate, check and zero-emit states
// a valid result passes the accumulate, check, mean, scale and emit states; W = 21 + clog2(MAX_BURST+1) is
// the width of the shared divider running mean and scaling one bit per cycle; done cannot be held off
// asynchronous active-low reset clears the burst state and loads the register defaults
module echo_burst_gated_average #(
    parameter int MAX_BURST = ebga_pkg::DEF_MAX_BURST
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ebga_pkg::ebga_in_t          sample,
    output logic                        done,
    output ebga_pkg::ebga_out_t         result,
    input  logic                        cfg_we,
    input  ebga_pkg::ebga_reg_e         cfg_index,
    input  logic [ebga_pkg::CFG_W-1:0]  cfg_data
);
    import ebga_pkg::*;

    ebga_cmd_t    cmd;
    ebga_status_t status;

    // sequencing
    ebga_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // arithmetic and storage
    ebga_dp #(
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

endmodule

### tb/echo_burst_gated_average_tb.sv
// self-checking testbench for the gated echo burst averager
module echo_burst_gated_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ebga_pkg::*;

    localparam int SETTLE_CYCLES  = 80;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SEGMENTS       = 12;
    localparam int SEGMENT_ECHOES = 90;
    localparam int PLAN_ROWS      = 40;

    typedef enum logic {ROW_ECHO, ROW_WRITE} row_kind_e;

    // one line of the directed plan
    typedef struct packed {
        row_kind_e            kind;
        ebga_reg_e            index;
        logic [CFG_W-1:0]     value;
        logic                 timed_out;
        logic [TICKS_W-1:0]   ticks;
        logic                 checked;
        logic [DIST_W-1:0]    want_dist;
        logic                 want_valid;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    ebga_in_t            sample;
    logic                done;
    ebga_out_t           result;
    logic                cfg_we;
    ebga_reg_e           cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    // register mirror
    logic [LEN_W-1:0]    mirror_len     = RST_BURST_LENGTH;
    logic [DIVR_W-1:0]   mirror_divisor = RST_SCALE_DIVISOR;
    logic [TOL_W-1:0]    mirror_tol     = RST_TOLERANCE;
    logic [MINV_W-1:0]   mirror_min     = RST_MIN_VALID;

    // burst state of the averaging model
    logic [5:0]          burst_count = '0;
    logic [5:0]          taken_count = '0;
    logic [DIST_W-1:0]   last_taken  = '0;
    logic [25:0]         burst_sum   = '0;

    ebga_out_t           pending_averages [$];

    int                  mismatches     = 0;
    int                  echoes_sent    = 0;
    int                  averages_seen  = 0;
    int                  valid_seen     = 0;
    int                  settings_tried = 0;

    // directed plan: reset defaults, field extremes, register corner values
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1000,  1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1000,  1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b1, 16'd65535, 1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1000,  1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1000,  1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1000,  1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1000,  1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1000,  1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1000,  1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1000,  1'b1, 21'd180,     1'b1},
        '{ROW_WRITE, REG_BURST_LENGTH,  10'd1,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_WRITE, REG_MIN_VALID,     10'd0,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_WRITE, REG_SCALE_DIVISOR, 10'd1,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd0,     1'b1, 21'd0,       1'b1},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd65535, 1'b1, 21'd1179630, 1'b1},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b1, 16'd0,     1'b1, 21'd0,       1'b0},
        '{ROW_WRITE, REG_SCALE_DIVISOR, 10'd0,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd65535, 1'b1, 21'd1179630, 1'b1},
        '{ROW_WRITE, REG_SCALE_DIVISOR, 10'd1023, 1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd65535, 1'b1, 21'd1153,    1'b1},
        '{ROW_WRITE, REG_MIN_VALID,     10'd63,   1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd100,   1'b1, 21'd0,       1'b0},
        '{ROW_WRITE, REG_MIN_VALID,     10'd0,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_WRITE, REG_SCALE_DIVISOR, 10'd1,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_WRITE, REG_BURST_LENGTH,  10'd0,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd5,     1'b1, 21'd90,      1'b1},
        '{ROW_WRITE, REG_BURST_LENGTH,  10'd3,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_WRITE, REG_TOLERANCE,     10'd0,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd10,    1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd10,    1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd11,    1'b1, 21'd180,     1'b1},
        '{ROW_WRITE, REG_TOLERANCE,     10'd1023, 1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_WRITE, REG_BURST_LENGTH,  10'd2,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd10,    1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd0,     1'b1, 21'd90,      1'b1},
        '{ROW_WRITE, REG_BURST_LENGTH,  10'd4,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd1,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd2,     1'b0, 21'd0,       1'b0},
        '{ROW_WRITE, REG_BURST_LENGTH,  10'd1,    1'b0, 16'd0,     1'b0, 21'd0,       1'b0},
        '{ROW_ECHO,  REG_BURST_LENGTH,  10'd0,    1'b0, 16'd3,     1'b1, 21'd36,      1'b1}
    };

    echo_burst_gated_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("%0t: timeout with %0d averages outstanding", $time, pending_averages.size());
        $display("echo_burst_gated_average regression: fail");
        $finish;
    end

    // gate one echo into the burst, produce the average when the burst closes
    task automatic fold_echo(input ebga_in_t echo, output bit closes, output ebga_out_t avg);
        logic [31:0] echo_dist;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mean;
        logic [31:0] divisor;
        logic [5:0]  span;
        bit          take;
        echo_dist = 32'(echo.echo_ticks) * 32'(TICK_FACTOR);
        avg       = '0;
        closes    = 1'b0;
        if (!echo.timed_out)
        begin
            if (taken_count == 0)
                take = 1'b1;
            else
            begin
                lo   = (32'(last_taken) > 32'(mirror_tol)) ? 32'(last_taken) - 32'(mirror_tol) : 32'd0;
                hi   = 32'(last_taken) + 32'(mirror_tol);
                take = (echo_dist >= lo) && (echo_dist <= hi);
            end
            if (take)
            begin
                last_taken  = echo_dist[DIST_W-1:0];
                burst_sum   = burst_sum + echo_dist[25:0];
                taken_count = taken_count + 1'b1;
            end
        end
        burst_count = burst_count + 1'b1;
        // zero length acts as one, oversized lengths clamp to the burst capacity
        if (mirror_len == 0)
            span = 6'd1;
        else if (mirror_len > DEF_MAX_BURST)
            span = 6'(DEF_MAX_BURST);
        else
            span = mirror_len;
        if (burst_count >= span)
        begin
            closes = 1'b1;
            if (taken_count > mirror_min && taken_count != 0)
            begin
                mean                = 32'(burst_sum) / 32'(taken_count);
                divisor             = (mirror_divisor == 0) ? 32'd1 : 32'(mirror_divisor);
                avg.distance_scaled = DIST_W'(mean / divisor);
                avg.result_valid    = 1'b1;
            end
            burst_count = '0;
            taken_count = '0;
            last_taken  = '0;
            burst_sum   = '0;
        end
    endtask

    // hold start high until the echo is taken
    task automatic offer_echo(input ebga_in_t echo);
        start  <= 1'b1;
        sample <= echo;
        do
            @(posedge clk);
        while (busy);
        echoes_sent++;
    endtask

    // wait for all outstanding averages, then let the divider go quiet
    task automatic drain_averages();
        start <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write and mirror update; caller drops cfg_we
    task automatic write_reg(input ebga_reg_e index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            REG_BURST_LENGTH:  mirror_len     = value[LEN_W-1:0];
            REG_SCALE_DIVISOR: mirror_divisor = value[DIVR_W-1:0];
            REG_TOLERANCE:     mirror_tol     = value[TOL_W-1:0];
            REG_MIN_VALID:     mirror_min     = value[MINV_W-1:0];
            default: ;
        endcase
    endtask

    // compare each strobed average with the oldest expectation
    always @(posedge clk)
    begin : average_check
        ebga_out_t want;
        if (rst_n && done)
        begin
            averages_seen++;
            if (result.result_valid === 1'b1)
                valid_seen++;
            if (pending_averages.size() == 0)
            begin
                $display("%0t: average with none expected: dist %0d valid %0b",
                         $time, result.distance_scaled, result.result_valid);
                mismatches++;
            end
            else
            begin
                want = pending_averages.pop_front();
                if (result.distance_scaled !== want.distance_scaled)
                begin
                    $display("%0t: distance_scaled expected %0d actual %0d",
                             $time, want.distance_scaled, result.distance_scaled);
                    mismatches++;
                end
                if (result.result_valid !== want.result_valid)
                begin
                    $display("%0t: result_valid expected %0b actual %0b",
                             $time, want.result_valid, result.result_valid);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        ebga_in_t  echo;
        ebga_out_t avg;
        ebga_out_t typed;
        bit        closes;
        int        idle_pct;
        int        base;
        int        reach;
        int        ticks;
        int        roll;
        int        waited;
        logic [LEN_W-1:0]  len;
        logic [DIVR_W-1:0] divisor;
        logic [TOL_W-1:0]  tol;
        logic [MINV_W-1:0] min_ok;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        sample    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_BURST_LENGTH;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_WRITE)
            begin
                drain_averages();
                write_reg(plan[r].index, plan[r].value);
                cfg_we <= 1'b0;
                settings_tried++;
            end
            else
            begin
                echo.timed_out  = plan[r].timed_out;
                echo.echo_ticks = plan[r].ticks;
                offer_echo(echo);
                fold_echo(echo, closes, avg);
                typed.distance_scaled = plan[r].want_dist;
                typed.result_valid    = plan[r].want_valid;
                if (closes)
                    pending_averages.push_back(plan[r].checked ? typed : avg);
                if (r + 1 >= PLAN_ROWS || plan[r + 1].kind != ROW_ECHO)
                    start <= 1'b0;
            end
        end

        // random segments, each with its own register setting
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_pct = (seg < 4) ? 19 : (seg < 8) ? 81 : 0;
            case ($urandom_range(5))
                0:       len = 6'd1;
                1:       len = 6'd0;
                2:       len = 6'($urandom_range(9, 32));
                default: len = 6'($urandom_range(2, 8));
            endcase
            case ($urandom_range(4))
                0:       divisor = 10'd0;
                1:       divisor = 10'd1;
                2:       divisor = 10'd1023;
                default: divisor = 10'($urandom_range(2, 1022));
            endcase
            case ($urandom_range(4))
                0:       tol = 10'd0;
                1:       tol = 10'd1023;
                default: tol = 10'($urandom_range(1, 300));
            endcase
            min_ok = (len > 1) ? 6'($urandom_range(0, len - 1)) : 6'd0;
            if ($urandom_range(5) == 0)
                min_ok = 6'($urandom_range(0, 63));
            // force the far ends of length and threshold once each
            if (seg == 1)
            begin
                len    = 6'd63;
                min_ok = 6'd31;
            end
            if (seg == 6)
            begin
                len    = 6'd32;
                min_ok = 6'd32;
            end
            drain_averages();
            write_reg(REG_BURST_LENGTH, CFG_W'(len));
            write_reg(REG_SCALE_DIVISOR, CFG_W'(divisor));
            write_reg(REG_TOLERANCE, CFG_W'(tol));
            write_reg(REG_MIN_VALID, CFG_W'(min_ok));
            cfg_we <= 1'b0;
            settings_tried++;

            base = $urandom_range(0, 65535);
            for (int k = 0; k < SEGMENT_ECHOES; k++)
            begin
                // sender gaps, and now and then a full drain
                if ($urandom_range(99) == 0)
                begin
                    start <= 1'b0;
                    while (pending_averages.size() != 0)
                        @(posedge clk);
                end
                else
                begin
                    while ($urandom_range(99) < idle_pct)
                    begin
                        start <= 1'b0;
                        @(posedge clk);
                    end
                end

                // mostly echoes clustered inside the window, some noise
                roll  = $urandom_range(99);
                reach = int'(mirror_tol) / 18 + 1;
                echo.timed_out = (roll < 10);
                if (roll < 10 || (roll >= 75 && roll < 85))
                    ticks = $urandom_range(0, 65535);
                else if (roll < 90)
                    ticks = $urandom_range(1) ? 65535 : 0;
                else
                begin
                    if (roll >= 95)
                        base = $urandom_range(0, 65535);
                    ticks = base + $urandom_range(0, 2 * reach) - reach;
                    if (ticks < 0)
                        ticks = 0;
                    if (ticks > 65535)
                        ticks = 65535;
                end
                if (roll >= 10 && roll < 75)
                begin
                    ticks = base + $urandom_range(0, 2 * reach) - reach;
                    if (ticks < 0)
                        ticks = 0;
                    if (ticks > 65535)
                        ticks = 65535;
                end
                echo.echo_ticks = TICKS_W'(ticks);
                offer_echo(echo);
                fold_echo(echo, closes, avg);
                if (closes)
                    pending_averages.push_back(avg);
            end
            start <= 1'b0;
        end

        // drain with a bound, then let any stray strobe show up
        waited = 0;
        while (pending_averages.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_averages.size() != 0)
        begin
            $display("%0t: %0d averages never arrived", $time, pending_averages.size());
            $display("echo_burst_gated_average regression: fail");
            $finish;
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            $display("run covered %0d echoes over %0d register settings", echoes_sent,
                     settings_tried);
            $display("checked %0d burst averages, %0d of them valid", averages_seen,
                     valid_seen);
            if (mismatches == 0)
                $display("echo_burst_gated_average regression: pass");
            else
                $display("echo_burst_gated_average regression: fail");
            $finish;
        end
    end

endmodule
